[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk_i, the run form disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every rising clock edge, also during reset
`define ASSERT_ALL(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[src/adsr_pkg.sv]
// ----------------------------------------------------------------------------
// adsr_pkg
// types, widths and codes shared by the envelope generator modules
// ----------------------------------------------------------------------------
`default_nettype none

package adsr_pkg;

  localparam int TimeBits      = 32;
  localparam int LevelFracBits = 15;
  localparam int LevelBits     = LevelFracBits + 1;
  localparam int DurBits       = 16;
  localparam int KindBits      = 2;
  localparam int PhaseBits     = 3;
  localparam int CfgIdxBits    = 2;
  localparam int ProdBits      = DurBits + LevelBits;
  localparam int QuoBits       = ProdBits - DurBits;
  localparam int DivCntBits    = $clog2(QuoBits);

  localparam logic [LevelBits-1:0] FullScale = LevelBits'(64'd1 << LevelFracBits);

  typedef enum logic [PhaseBits-1:0] {
    PH_IDLE    = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_e;

  typedef enum logic [KindBits-1:0] {
    KIND_TICK     = 2'd0,
    KIND_NOTE_ON  = 2'd1,
    KIND_NOTE_OFF = 2'd2
  } kind_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_ATTACK  = 2'd0,
    CFG_DECAY   = 2'd1,
    CFG_SUSTAIN = 2'd2,
    CFG_RELEASE = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_WAIT,
    ST_EVAL,
    ST_MUL,
    ST_DIVGO,
    ST_DIV,
    ST_DONE
  } fsm_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

[src/adsr_div.sv]
// ----------------------------------------------------------------------------
// adsr_div
// restoring divider, one quotient bit per cycle through a shared subtractor
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [adsr_pkg::ProdBits-1:0] dividend_i,
  input  logic [adsr_pkg::DurBits-1:0]  divisor_i,
  output adsr_pkg::div_stat_t         stat_o,
  output logic [adsr_pkg::QuoBits-1:0]  quotient_o
);
  import adsr_pkg::*;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DivCntBits-1:0] cnt_q, cnt_d;
  logic [DurBits-1:0]    rem_q, rem_d;
  logic [QuoBits-1:0]    quo_q, quo_d;
  logic [DurBits-1:0]    dvs_q, dvs_d;
  logic [DurBits:0]      trial;
  logic                  ge;

  // dividend is known to be below divisor * 2^QuoBits
  assign trial = {rem_q, quo_q[QuoBits-1]} - {1'b0, dvs_q};
  assign ge    = ~trial[DurBits];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DivCntBits'(QuoBits - 1);
      rem_d  = dividend_i[ProdBits-1:QuoBits];
      quo_d  = dividend_i[QuoBits-1:0];
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? trial[DurBits-1:0] : {rem_q[DurBits-2:0], quo_q[QuoBits-1]};
      quo_d = {quo_q[QuoBits-2:0], ge};
      cnt_d = cnt_q - DivCntBits'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

`default_nettype wire

[src/adsr_envelope_generator.sv]
// ----------------------------------------------------------------------------
// adsr_envelope_generator
// linear attack/decay/sustain/release envelope, Q1.15 level, 32-bit time
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//  in      | in        | in_valid_i/in_ready_o   | kind_i, now_time_i
//  out     | out       | out_valid_o/out_ready_i | level_o, phase_o, idle_o
//
//  ramp ticks pass through evaluate, multiply, divider start, 16 divider
//  steps, divider done flag, result load and the accept state
//  note-on, note-off, unused kind, sustain, idle, end-of-ramp ticks: no divide
//  one transaction is in flight at a time; the next is taken once the result
//  sits in the output register, which holds it while out_ready_i is low
//  reset clears configuration, envelope state and the output valid flag
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_envelope_generator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [adsr_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  logic [adsr_pkg::DurBits-1:0]    cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [adsr_pkg::KindBits-1:0]   kind_i,
  input  logic [adsr_pkg::TimeBits-1:0]   now_time_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [adsr_pkg::LevelBits-1:0]  level_o,
  output logic [adsr_pkg::PhaseBits-1:0]  phase_o,
  output logic                            idle_o
);
  import adsr_pkg::*;

  fsm_e                 fsm_q, fsm_d;
  logic [KindBits-1:0]  kind_q;
  logic [TimeBits-1:0]  now_q;
  logic [DurBits-1:0]   attack_q, decay_q, release_q;
  logic [LevelBits-1:0] sustain_q;

  phase_e               phase_q, phase_d;
  logic [LevelBits-1:0] level_q, level_d;
  logic [TimeBits-1:0]  start_time_q, start_time_d;
  logic                 start_valid_q, start_valid_d;
  logic [LevelBits-1:0] start_level_q, start_level_d;

  logic [DurBits-1:0]   mul_a_q, mul_a_d;
  logic [LevelBits-1:0] mul_b_q, mul_b_d;
  logic                 ramp_up_q, ramp_up_d;
  logic [ProdBits-1:0]  prod_q;

  logic                 out_valid_q;
  logic [LevelBits-1:0] out_level_q;
  phase_e               out_phase_q;

  logic                 in_fire, cfg_fire, out_load, div_start, need_div;
  div_stat_t            div_stat;
  logic [QuoBits-1:0]   quo;

  logic [TimeBits-1:0]  start_t, elapsed;
  logic [LevelBits-1:0] sus_tgt, base, tgt, span;
  logic [DurBits-1:0]   dur;
  logic                 expired, ramp_done;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;
  assign in_fire     = in_valid_i & in_ready_o;

  // ramp operands
  always_comb begin
    start_t = start_valid_q ? start_time_q : now_q;
    elapsed = now_q - start_t;
    sus_tgt = (sustain_q > FullScale) ? FullScale : sustain_q;
    dur     = '0;
    base    = '0;
    tgt     = '0;
    unique case (phase_q)
      PH_ATTACK: begin
        dur = attack_q;
        tgt = FullScale;
      end
      PH_DECAY: begin
        dur  = decay_q;
        base = start_level_q;
        tgt  = sus_tgt;
      end
      PH_RELEASE: begin
        dur  = release_q;
        base = start_level_q;
      end
      default: begin
        dur = '0;
      end
    endcase
    expired   = (dur == '0) || (elapsed >= TimeBits'(dur));
    ramp_done = (phase_q == PH_ATTACK) ? expired : ((base <= tgt) || expired);
    span      = (phase_q == PH_ATTACK) ? FullScale : (base - tgt);
  end

  // envelope state update
  always_comb begin
    phase_d       = phase_q;
    level_d       = level_q;
    start_time_d  = start_time_q;
    start_valid_d = start_valid_q;
    start_level_d = start_level_q;
    mul_a_d       = mul_a_q;
    mul_b_d       = mul_b_q;
    ramp_up_d     = ramp_up_q;
    need_div      = 1'b0;
    if (fsm_q == ST_EVAL) begin
      unique case (kind_q)
        KIND_TICK: begin
          unique case (phase_q)
            PH_ATTACK, PH_DECAY, PH_RELEASE: begin
              start_time_d  = start_t;
              start_valid_d = 1'b1;
              if (ramp_done) begin
                start_valid_d = 1'b0;
                unique case (phase_q)
                  PH_ATTACK: begin
                    phase_d       = PH_DECAY;
                    level_d       = FullScale;
                    start_level_d = FullScale;
                  end
                  PH_DECAY: begin
                    phase_d = PH_SUSTAIN;
                    level_d = sus_tgt;
                  end
                  default: begin
                    phase_d = PH_IDLE;
                    level_d = '0;
                  end
                endcase
              end else begin
                need_div  = 1'b1;
                mul_a_d   = elapsed[DurBits-1:0];
                mul_b_d   = span;
                ramp_up_d = (phase_q == PH_ATTACK);
              end
            end
            PH_SUSTAIN: begin
              start_valid_d = 1'b0;
              if (level_q == '0) begin
                phase_d = PH_IDLE;
              end
            end
            PH_IDLE: begin
              phase_d = PH_IDLE;
            end
            default: begin
              phase_d = PH_IDLE;
            end
          endcase
        end
        KIND_NOTE_ON: begin
          phase_d       = PH_ATTACK;
          level_d       = '0;
          start_valid_d = 1'b0;
          start_level_d = '0;
        end
        KIND_NOTE_OFF: begin
          if (phase_q != PH_IDLE) begin
            phase_d       = PH_RELEASE;
            start_valid_d = 1'b0;
            start_level_d = level_q;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end else if ((fsm_q == ST_DIV) && div_stat.done) begin
      level_d = ramp_up_q ? quo : (start_level_q - quo);
    end
  end

  // sequencer next state
  always_comb begin
    fsm_d = fsm_q;
    unique case (fsm_q)
      ST_WAIT:  if (in_fire) fsm_d = ST_EVAL;
      ST_EVAL:  fsm_d = need_div ? ST_MUL : ST_DONE;
      ST_MUL:   fsm_d = ST_DIVGO;
      ST_DIVGO: fsm_d = ST_DIV;
      ST_DIV:   if (div_stat.done) fsm_d = ST_DONE;
      ST_DONE:  if (!out_valid_q || out_ready_i) fsm_d = ST_WAIT;
      default:  fsm_d = ST_WAIT;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (fsm_q)
      ST_WAIT:  in_ready_o = 1'b1;
      ST_DIVGO: div_start  = 1'b1;
      ST_DONE:  out_load   = !out_valid_q || out_ready_i;
      default:  in_ready_o = 1'b0;
    endcase
  end

  adsr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (dur),
    .stat_o     (div_stat),
    .quotient_o (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q         <= ST_WAIT;
      phase_q       <= PH_IDLE;
      level_q       <= '0;
      start_time_q  <= '0;
      start_valid_q <= 1'b0;
      start_level_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      fsm_q         <= fsm_d;
      phase_q       <= phase_d;
      level_q       <= level_d;
      start_time_q  <= start_time_d;
      start_valid_q <= start_valid_d;
      start_level_q <= start_level_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= '0;
      decay_q   <= '0;
      sustain_q <= '0;
      release_q <= '0;
    end else if (cfg_fire) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ATTACK:  attack_q  <= cfg_data_i;
        CFG_DECAY:   decay_q   <= cfg_data_i;
        CFG_SUSTAIN: sustain_q <= LevelBits'(cfg_data_i);
        CFG_RELEASE: release_q <= cfg_data_i;
        default:     attack_q  <= attack_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q <= kind_i;
      now_q  <= now_time_i;
    end
    mul_a_q   <= mul_a_d;
    mul_b_q   <= mul_b_d;
    ramp_up_q <= ramp_up_d;
    if (fsm_q == ST_MUL) begin
      prod_q <= ProdBits'(mul_a_q) * ProdBits'(mul_b_q);
    end
    if (out_load) begin
      out_level_q <= level_q;
      out_phase_q <= phase_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign level_o     = out_level_q;
  assign phase_o     = out_phase_q;
  assign idle_o      = (out_phase_q == PH_IDLE);

endmodule

`default_nettype wire

[src/adsr_checker.sv]
// ----------------------------------------------------------------------------
// adsr_checker
// port-level checks on the envelope generator, attached by bind
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module adsr_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o,
  input logic [adsr_pkg::CfgIdxBits-1:0] cfg_index_i,
  input logic [adsr_pkg::DurBits-1:0]    cfg_data_i,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic [adsr_pkg::KindBits-1:0]   kind_i,
  input logic [adsr_pkg::TimeBits-1:0]   now_time_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [adsr_pkg::LevelBits-1:0]  level_o,
  input logic [adsr_pkg::PhaseBits-1:0]  phase_o,
  input logic                            idle_o
);
  import adsr_pkg::*;

  logic unused_ok;
  assign unused_ok = cfg_valid_i ^ cfg_ready_o ^ (^cfg_index_i) ^ (^cfg_data_i)
                     ^ (^kind_i) ^ (^now_time_i);

  `ASSERT_RUN(a_idle_flag, out_valid_o |-> (idle_o == (phase_o == PH_IDLE)), "idle flag mismatch")
  `ASSERT_RUN(a_level_range, out_valid_o |-> (level_o <= FullScale), "level above full scale")
  `ASSERT_RUN(a_idle_silent, (out_valid_o && idle_o) |-> (level_o == '0), "idle with nonzero level")
  `ASSERT_RUN(a_one_in_flight, (in_valid_i && in_ready_o) |=> !in_ready_o, "back-to-back accept")
  `ASSERT_RUN(a_out_hold, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(level_o)), "stalled result changed")

endmodule

bind adsr_envelope_generator adsr_checker u_adsr_checker (.*);

`default_nettype wire

[verif/adsr_envelope_generator_tb.sv]
// ----------------------------------------------------------------------------
// adsr_envelope_generator_tb
// self-checking bench for the linear envelope generator: a directed list of
// transactions and register writes walks every phase and corner, then random
// note-on/tick/note-off runs under changing settings, all scored in order against the
// expected value a directed row carries, else an envelope predictor kept inside the bench
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_envelope_generator_tb;
  import adsr_pkg::*;

  localparam logic [KindBits-1:0] KindUnused = 2'd3;
  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned SettlePause = 32;
  localparam int          TargetItems = 750;

  typedef struct packed {
    logic [LevelBits-1:0] level;
    phase_e               phase;
    logic                 idle;
  } env_result_t;

  typedef struct packed {
    logic                is_cfg;
    cfg_idx_e            idx;
    logic [DurBits-1:0]  data;
    logic [KindBits-1:0] kind;
    logic [TimeBits-1:0] stamp;
    logic                typed;
    env_result_t         res;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CfgIdxBits-1:0] cfg_index;
  logic [DurBits-1:0]    cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [KindBits-1:0]   kind;
  logic [TimeBits-1:0]   now_t;
  logic                  out_valid;
  logic                  out_ready;
  logic [LevelBits-1:0]  level;
  logic [PhaseBits-1:0]  phase;
  logic                  idle;

  // expected value riding along with a directed transaction
  logic                  row_typed;
  env_result_t           row_result;

  // envelope predictor state and its copy of the registers
  logic [DurBits-1:0]    attack_len, decay_len, sustain_set, release_len;
  phase_e                env_phase;
  logic [LevelBits-1:0]  env_level;
  logic [LevelBits-1:0]  ramp_from;
  logic [TimeBits-1:0]   ramp_t0;
  logic                  ramp_t0_ok;

  env_result_t           pending_results[$];
  env_result_t           oldest;
  env_result_t           predicted;
  stim_row_t             stim_rows[$];

  logic                  idling_on;
  logic [TimeBits-1:0]   clock_now;
  int unsigned           tick_cap;
  int unsigned           cycles;
  int                    fails;
  int                    checked;
  int                    cfg_writes;
  int                    live_items;
  int                    settings_used;

  adsr_envelope_generator u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .kind_i     (kind),
    .now_time_i (now_t),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .level_o    (level),
    .phase_o    (phase),
    .idle_o     (idle)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [LevelBits-1:0] ramp_down(input logic [LevelBits-1:0] from,
                                                     input logic [LevelBits-1:0] target,
                                                     input logic [TimeBits-1:0]  e,
                                                     input logic [DurBits-1:0]   dur);
    longint unsigned drop;
    if (from <= target || dur == '0 || e >= dur) return target;
    drop = (64'(from - target) * 64'(e)) / 64'(dur);
    return from - LevelBits'(drop);
  endfunction

  function automatic void advance_envelope(input logic [KindBits-1:0] k,
                                           input logic [TimeBits-1:0] stamp);
    logic [TimeBits-1:0]  e;
    logic [LevelBits-1:0] tgt;
    logic [LevelBits-1:0] lvl;
    case (k)
      KIND_TICK: if (env_phase != PH_IDLE) begin
        if (!ramp_t0_ok) begin
          ramp_t0    = stamp;
          ramp_t0_ok = 1'b1;
        end
        e = stamp - ramp_t0;
        case (env_phase)
          PH_ATTACK: begin
            if (attack_len == '0 || e >= attack_len) lvl = FullScale;
            else lvl = LevelBits'((64'(e) << LevelFracBits) / 64'(attack_len));
            env_level = lvl;
            if (lvl >= FullScale) begin
              env_phase  = PH_DECAY;
              env_level  = FullScale;
              ramp_t0_ok = 1'b0;
              ramp_from  = FullScale;
            end
          end
          PH_DECAY: begin
            tgt = (sustain_set > FullScale) ? FullScale : sustain_set;
            lvl = ramp_down(ramp_from, tgt, e, decay_len);
            env_level = lvl;
            if (lvl <= tgt) begin
              env_phase  = PH_SUSTAIN;
              env_level  = tgt;
              ramp_t0_ok = 1'b0;
            end
          end
          PH_SUSTAIN: begin
            ramp_t0_ok = 1'b0;
            if (env_level == '0) env_phase = PH_IDLE;
          end
          PH_RELEASE: begin
            lvl = ramp_down(ramp_from, '0, e, release_len);
            env_level = lvl;
            if (lvl == '0) begin
              env_phase  = PH_IDLE;
              env_level  = '0;
              ramp_t0_ok = 1'b0;
            end
          end
          default: env_phase = PH_IDLE;
        endcase
      end
      KIND_NOTE_ON: begin
        env_phase  = PH_ATTACK;
        env_level  = '0;
        ramp_t0_ok = 1'b0;
        ramp_from  = '0;
      end
      KIND_NOTE_OFF: if (env_phase != PH_IDLE) begin
        env_phase  = PH_RELEASE;
        ramp_t0_ok = 1'b0;
        ramp_from  = env_level;
      end
      default: ;
    endcase
  endfunction

  // register writes, accepted transactions and result scoring
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ATTACK:  attack_len  = cfg_data;
          CFG_DECAY:   decay_len   = cfg_data;
          CFG_SUSTAIN: sustain_set = cfg_data;
          CFG_RELEASE: release_len = cfg_data;
          default: ;
        endcase
        cfg_writes++;
      end
      if (in_valid && in_ready) begin
        live_items++;
        advance_envelope(kind, now_t);
        predicted.level = env_level;
        predicted.phase = env_phase;
        predicted.idle  = (env_phase == PH_IDLE);
        pending_results.push_back(row_typed ? row_result : predicted);
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result with no transaction waiting: level %0d phase %0d", level, phase);
          fails++;
        end else begin
          oldest = pending_results.pop_front();
          if (level !== oldest.level) begin
            $error("level mismatch: expected %0d, actual %0d", oldest.level, level);
            fails++;
          end
          if (phase !== oldest.phase) begin
            $error("phase mismatch: expected %0d, actual %0d", oldest.phase, phase);
            fails++;
          end
          if (idle !== oldest.idle) begin
            $error("idle mismatch: expected %0d, actual %0d", oldest.idle, idle);
            fails++;
          end
          checked++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $error("timeout after %0d cycles, %0d results outstanding", cycles,
             pending_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver stalls in bursts
  initial begin
    int stall;
    stall     = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ready = 1'b0;
        stall--;
      end else begin
        out_ready = 1'b1;
        if (idling_on && $urandom_range(0, 9) == 0) stall = $urandom_range(1, 17);
      end
    end
  end

  function automatic void add_item(input logic [KindBits-1:0] k, input logic [TimeBits-1:0] t);
    stim_row_t r;
    r       = '0;
    r.kind  = k;
    r.stamp = t;
    stim_rows.push_back(r);
  endfunction

  function automatic void add_known(input logic [KindBits-1:0] k, input logic [TimeBits-1:0] t,
                                    input logic [LevelBits-1:0] lvl, input phase_e ph);
    stim_row_t r;
    r           = '0;
    r.kind      = k;
    r.stamp     = t;
    r.typed     = 1'b1;
    r.res.level = lvl;
    r.res.phase = ph;
    r.res.idle  = (ph == PH_IDLE);
    stim_rows.push_back(r);
  endfunction

  function automatic void add_cfg(input cfg_idx_e idx, input logic [DurBits-1:0] value);
    stim_row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = value;
    stim_rows.push_back(r);
  endfunction

  function automatic logic [DurBits-1:0] pick_duration();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 16'd1;
      2:       return 16'hFFFF;
      3, 4:    return DurBits'($urandom_range(2, 64));
      default: return DurBits'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [DurBits-1:0] pick_sustain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return FullScale;
      2:       return 16'hFFFF;
      3:       return DurBits'($urandom_range(32769, 65535));
      default: return DurBits'($urandom_range(0, 32768));
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input logic [KindBits-1:0] k, input logic [TimeBits-1:0] t,
                           input logic typed, input env_result_t res);
    int gap;
    if (idling_on && $urandom_range(0, 7) == 0) begin
      gap      = $urandom_range(1, 17);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   = 1'b1;
    kind       = k;
    now_t      = t;
    row_typed  = typed;
    row_result = res;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_tick();
    if ($urandom_range(0, 15) == 0) clock_now = $urandom;
    else clock_now = clock_now + $urandom_range(0, tick_cap);
    send_item(KIND_TICK, clock_now, 1'b0, '0);
  endtask

  task automatic send_noise();
    send_item(KindBits'($urandom_range(0, 3)), $urandom, 1'b0, '0);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [DurBits-1:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // wait for every outstanding result, then let the block go quiet
  task automatic settle();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SettlePause) @(negedge clk);
  endtask

  // one note: attack, maybe decay and sustain, release
  task automatic play_envelope();
    int n;
    send_item(KIND_NOTE_ON, $urandom, 1'b0, '0);
    n = $urandom_range(1, 10);
    repeat (n) begin
      send_tick();
      if ($urandom_range(0, 11) == 0) send_noise();
    end
    send_item(KIND_NOTE_OFF, $urandom, 1'b0, '0);
    n = $urandom_range(1, 8);
    repeat (n) send_tick();
    if ($urandom_range(0, 5) == 0) send_noise();
  endtask

  initial begin
    int unsigned longest;
    int          notes;
    rst_n       = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    kind        = '0;
    now_t       = '0;
    row_typed   = 1'b0;
    row_result  = '0;
    idling_on   = 1'b1;
    attack_len  = '0;
    decay_len   = '0;
    sustain_set = '0;
    release_len = '0;
    env_phase   = PH_IDLE;
    env_level   = '0;
    ramp_from   = '0;
    ramp_t0     = '0;
    ramp_t0_ok  = 1'b0;
    clock_now   = '0;
    tick_cap    = 1;
    cycles      = 0;
    fails       = 0;
    checked     = 0;
    cfg_writes  = 0;
    live_items  = 0;
    settings_used = 0;

    // reset defaults: instant ramps, zero sustain
    add_known(KIND_TICK, 32'h0000_0000, '0, PH_IDLE);
    add_known(KIND_NOTE_OFF, 32'hFFFF_FFFF, '0, PH_IDLE);
    add_known(KindUnused, 32'h5A5A_A5A5, '0, PH_IDLE);
    add_known(KIND_NOTE_ON, 32'h0000_0000, '0, PH_ATTACK);
    add_known(KIND_TICK, 32'hFFFF_FFFF, FullScale, PH_DECAY);
    add_known(KIND_TICK, 32'h0000_0000, '0, PH_SUSTAIN);
    add_known(KIND_TICK, 32'h0000_0001, '0, PH_IDLE);
    // short ramps through every phase
    add_cfg(CFG_ATTACK, 16'd8);
    add_cfg(CFG_DECAY, 16'd16);
    add_cfg(CFG_SUSTAIN, 16'h4000);
    add_cfg(CFG_RELEASE, 16'd8);
    add_known(KIND_NOTE_ON, 32'hA5A5_5A5A, '0, PH_ATTACK);
    add_known(KIND_TICK, 32'd100, '0, PH_ATTACK);
    add_item(KIND_TICK, 32'd104);
    add_known(KIND_TICK, 32'd108, FullScale, PH_DECAY);
    add_item(KIND_TICK, 32'd200);
    add_item(KIND_TICK, 32'd208);
    add_item(KIND_TICK, 32'd216);
    add_item(KIND_NOTE_OFF, 32'd0);
    add_item(KIND_TICK, 32'd400);
    add_item(KIND_TICK, 32'd404);
    add_item(KIND_NOTE_OFF, 32'd0);
    add_item(KIND_TICK, 32'd500);
    add_known(KIND_TICK, 32'd499, '0, PH_IDLE);
    // sustain above full scale, instant release
    add_cfg(CFG_SUSTAIN, 16'hFFFF);
    add_cfg(CFG_RELEASE, 16'd0);
    add_item(KIND_NOTE_ON, 32'd0);
    add_item(KIND_TICK, 32'hFFFF_FFFC);
    add_known(KIND_TICK, 32'd4, FullScale, PH_DECAY);
    add_known(KIND_TICK, 32'd5, FullScale, PH_SUSTAIN);
    add_known(KIND_NOTE_ON, 32'd6, '0, PH_ATTACK);
    add_item(KIND_NOTE_OFF, 32'd7);
    add_known(KIND_TICK, 32'd9, '0, PH_IDLE);

    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_cfg) begin
        settle();
        write_reg(stim_rows[i].idx, stim_rows[i].data);
      end else begin
        send_item(stim_rows[i].kind, stim_rows[i].stamp, stim_rows[i].typed,
                  stim_rows[i].res);
      end
    end

    while (live_items < TargetItems) begin
      settle();
      idling_on = (live_items < TargetItems - 100) && ($urandom_range(0, 3) != 0);
      write_reg(CFG_ATTACK, pick_duration());
      write_reg(CFG_DECAY, pick_duration());
      write_reg(CFG_SUSTAIN, pick_sustain());
      write_reg(CFG_RELEASE, pick_duration());
      settings_used++;
      longest = attack_len;
      if (decay_len > longest) longest = decay_len;
      if (release_len > longest) longest = release_len;
      tick_cap  = longest / 3 + 1;
      clock_now = $urandom;
      notes     = $urandom_range(2, 5);
      repeat (notes) play_envelope();
    end

    settle();
    $display("%0d results checked, %0d envelope transactions, %0d register writes",
             checked, live_items, cfg_writes);
    $display("%0d random register sets, durations up to full range, sustain above full scale",
             settings_used);
    if (fails == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire
